FILE: rtl/tqtc_pkg.sv
// Shared constants, codes and types of the track queue transport controller.
`timescale 1ns / 1ps

package tqtc_pkg;

    // Store sizes and track id width.
    localparam int QUEUE_DEPTH   = 16;
    localparam int HISTORY_DEPTH = 16;
    localparam int TRACK_BITS    = 16;

    localparam int QIDX_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int HIDX_W = $clog2(HISTORY_DEPTH);
    localparam int HCNT_W = $clog2(HISTORY_DEPTH + 1);

    // Port field widths.
    localparam int CMD_W      = 4;
    localparam int EVENT_W    = 4;
    localparam int TRACK_W    = 16;
    localparam int STATE_W    = 2;
    localparam int COUNT_W    = 5;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_APPEND   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD     = 4'd1;
    localparam logic [CMD_W-1:0] CMD_PLAY     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_PAUSE    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_STOP     = 4'd4;
    localparam logic [CMD_W-1:0] CMD_RESUME   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_END      = 4'd6;
    localparam logic [CMD_W-1:0] CMD_FORWARD  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_BACKWARD = 4'd8;

    // Event codes.
    localparam logic [EVENT_W-1:0] EV_NONE     = 4'd0;
    localparam logic [EVENT_W-1:0] EV_LOADED   = 4'd1;
    localparam logic [EVENT_W-1:0] EV_PLAYING  = 4'd2;
    localparam logic [EVENT_W-1:0] EV_PAUSED   = 4'd3;
    localparam logic [EVENT_W-1:0] EV_STOPPED  = 4'd4;
    localparam logic [EVENT_W-1:0] EV_RESUMED  = 4'd5;
    localparam logic [EVENT_W-1:0] EV_ENDED    = 4'd6;
    localparam logic [EVENT_W-1:0] EV_ADVANCED = 4'd7;
    localparam logic [EVENT_W-1:0] EV_RETURNED = 4'd8;
    localparam logic [EVENT_W-1:0] EV_APPENDED = 4'd9;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic capture;      // latch the incoming command
        logic read_first;   // address the queue head and history top
        logic read_second;  // latch first reads, address the entry after the head
        logic exec;         // apply the command and register the result
    } ctrl_t;

    // Fit an internal track id to the track field of the ports.
    function automatic logic [TRACK_W-1:0] to_field(input logic [TRACK_BITS-1:0] t);
        logic [31:0] wide;
        wide = 32'(t);
        return wide[TRACK_W-1:0];
    endfunction

endpackage

FILE: rtl/track_queue_transport_controller.sv
// Top level of the track queue transport controller.
// Each accepted command passes the read, latch and execute states; done is registered from execute.
// A new command is taken only while busy is low; the queue RAM has one read port and
// forward needs the head and the entry after it, read one after the other.
// Reset: asynchronous, active low; mode stopped, nothing loaded, both stores empty.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module track_queue_transport_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  command,
    input  logic [15:0] track_id,
    output logic        done,
    output logic [3:0]  event_res,
    output logic [15:0] reported_track,
    output logic [1:0]  player_state,
    output logic        loaded_valid,
    output logic [15:0] loaded_track,
    output logic [4:0]  queue_count,
    output logic [4:0]  history_count,
    output logic        dropped
);

    import tqtc_pkg::*;

    ctrl_t ctrl;

    // Command sequencer.
    tqtc_controller u_controller (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    // Stores, transport registers and result registers.
    tqtc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .command        (command),
        .track_id       (track_id),
        .done           (done),
        .event_res      (event_res),
        .reported_track (reported_track),
        .player_state   (player_state),
        .loaded_valid   (loaded_valid),
        .loaded_track   (loaded_track),
        .queue_count    (queue_count),
        .history_count  (history_count),
        .dropped        (dropped)
    );

endmodule

FILE: rtl/tqtc_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module tqtc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tqtc_datapath.sv
// Datapath: transport registers, queue and history stores, result registers.
`timescale 1ns / 1ps

module tqtc_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tqtc_pkg::ctrl_t        ctrl,
    input  logic [3:0]             command,
    input  logic [15:0]            track_id,
    output logic                   done,
    output logic [3:0]             event_res,
    output logic [15:0]            reported_track,
    output logic [1:0]             player_state,
    output logic                   loaded_valid,
    output logic [15:0]            loaded_track,
    output logic [4:0]             queue_count,
    output logic [4:0]             history_count,
    output logic                   dropped
);

    import tqtc_pkg::*;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_LOADED  = 2'd1,
        MODE_PLAYING = 2'd2,
        MODE_PAUSED  = 2'd3
    } mode_t;

    // Transport and store bookkeeping.
    mode_t                  mode_reg, mode_next;
    logic                   loaded_reg, loaded_next;
    logic [TRACK_BITS-1:0]  cur_reg, cur_next;
    logic [QIDX_W-1:0]      qhead_reg, qhead_next;
    logic [QIDX_W-1:0]      qtail_reg, qtail_next;
    logic [QCNT_W-1:0]      qfill_reg, qfill_next;
    logic [HCNT_W-1:0]      hfill_reg, hfill_next;

    // Latched command and first-read data.
    logic [CMD_W-1:0]       cmd_reg;
    logic [TRACK_BITS-1:0]  tid_reg;
    logic [TRACK_BITS-1:0]  first_reg;
    logic [TRACK_BITS-1:0]  top_reg;

    // Result registers.
    logic                   done_reg;
    logic [EVENT_W-1:0]     event_reg, event_next;
    logic [TRACK_BITS-1:0]  rep_reg, rep_next;
    logic                   drop_reg, drop_next;

    // Store ports.
    logic                   q_we;
    logic [QIDX_W-1:0]      q_waddr;
    logic [TRACK_BITS-1:0]  q_wdata;
    logic                   q_re;
    logic [QIDX_W-1:0]      q_raddr;
    logic [TRACK_BITS-1:0]  q_rdata;
    logic                   h_we;
    logic [HIDX_W-1:0]      h_waddr;
    logic [HIDX_W-1:0]      h_raddr;
    logic [TRACK_BITS-1:0]  h_rdata;

    logic                   q_full;
    logic                   h_full;

    function automatic logic [QIDX_W-1:0] q_inc(input logic [QIDX_W-1:0] p);
        return (p == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign q_full = (qfill_reg == QCNT_W'(QUEUE_DEPTH));
    assign h_full = (hfill_reg == HCNT_W'(HISTORY_DEPTH));

    // Read addresses: head then the entry after it; history top.
    assign q_re    = ctrl.read_first | ctrl.read_second;
    assign q_raddr = ctrl.read_second ? q_inc(qhead_reg) : qhead_reg;
    assign h_raddr = (hfill_reg == '0) ? '0 : HIDX_W'(hfill_reg - 1'b1);

    tqtc_ram #(
        .WIDTH (TRACK_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (q_re),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    tqtc_ram #(
        .WIDTH (TRACK_BITS),
        .DEPTH (HISTORY_DEPTH)
    ) u_history_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (first_reg),
        .re    (ctrl.read_first),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    // Command execution.
    always_comb
    begin
        mode_next   = mode_reg;
        loaded_next = loaded_reg;
        cur_next    = cur_reg;
        qhead_next  = qhead_reg;
        qtail_next  = qtail_reg;
        qfill_next  = qfill_reg;
        hfill_next  = hfill_reg;
        event_next  = EV_NONE;
        rep_next    = '0;
        drop_next   = 1'b0;
        q_we        = 1'b0;
        q_waddr     = qtail_reg;
        q_wdata     = tid_reg;
        h_we        = 1'b0;
        h_waddr     = hfill_reg[HIDX_W-1:0];

        if (ctrl.exec)
        begin
            case (cmd_reg)
                CMD_APPEND:
                begin
                    if (!q_full)
                    begin
                        q_we       = 1'b1;
                        qtail_next = q_inc(qtail_reg);
                        qfill_next = qfill_reg + 1'b1;
                        event_next = EV_APPENDED;
                        rep_next   = tid_reg;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
                CMD_LOAD:
                begin
                    if (mode_reg == MODE_STOPPED)
                    begin
                        loaded_next = 1'b0;
                        cur_next    = '0;
                        if (qfill_reg != '0)
                        begin
                            loaded_next = 1'b1;
                            cur_next    = first_reg;
                            mode_next   = MODE_LOADED;
                            event_next  = EV_LOADED;
                            rep_next    = first_reg;
                        end
                    end
                end
                CMD_PLAY:
                begin
                    if (mode_reg == MODE_LOADED)
                    begin
                        mode_next  = MODE_PLAYING;
                        event_next = EV_PLAYING;
                        rep_next   = cur_reg;
                    end
                end
                CMD_PAUSE:
                begin
                    if (mode_reg == MODE_PLAYING)
                    begin
                        mode_next  = MODE_PAUSED;
                        event_next = EV_PAUSED;
                        rep_next   = cur_reg;
                    end
                end
                CMD_STOP:
                begin
                    if (mode_reg != MODE_STOPPED)
                    begin
                        mode_next  = MODE_STOPPED;
                        event_next = EV_STOPPED;
                        rep_next   = loaded_reg ? cur_reg : '0;
                    end
                end
                CMD_RESUME:
                begin
                    if (mode_reg == MODE_PAUSED)
                    begin
                        mode_next  = MODE_PLAYING;
                        event_next = EV_RESUMED;
                        rep_next   = cur_reg;
                    end
                end
                CMD_END:
                begin
                    if (mode_reg == MODE_PLAYING)
                    begin
                        mode_next  = MODE_STOPPED;
                        event_next = EV_ENDED;
                        if (qfill_reg != '0)
                        begin
                            qhead_next = q_inc(qhead_reg);
                            qfill_next = qfill_reg - 1'b1;
                            rep_next   = first_reg;
                            if (!h_full)
                            begin
                                h_we       = 1'b1;
                                hfill_next = hfill_reg + 1'b1;
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                    end
                end
                CMD_FORWARD:
                begin
                    if (qfill_reg != '0)
                    begin
                        qhead_next = q_inc(qhead_reg);
                        qfill_next = qfill_reg - 1'b1;
                        // The new head came from the second queue read.
                        if (qfill_reg > QCNT_W'(1))
                        begin
                            loaded_next = 1'b1;
                            cur_next    = q_rdata;
                        end
                        else
                        begin
                            loaded_next = 1'b0;
                            cur_next    = '0;
                        end
                        if (!h_full)
                        begin
                            h_we       = 1'b1;
                            hfill_next = hfill_reg + 1'b1;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                        event_next = EV_ADVANCED;
                        rep_next   = first_reg;
                    end
                end
                CMD_BACKWARD:
                begin
                    if (hfill_reg != '0)
                    begin
                        hfill_next  = hfill_reg - 1'b1;
                        loaded_next = 1'b1;
                        cur_next    = top_reg;
                        q_wdata     = top_reg;
                        if (!q_full)
                        begin
                            q_we       = 1'b1;
                            qtail_next = q_inc(qtail_reg);
                            qfill_next = qfill_reg + 1'b1;
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                        event_next = EV_RETURNED;
                        rep_next   = top_reg;
                    end
                end
                default:
                begin
                    event_next = EV_NONE;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_STOPPED;
            loaded_reg <= 1'b0;
            cur_reg    <= '0;
            qhead_reg  <= '0;
            qtail_reg  <= '0;
            qfill_reg  <= '0;
            hfill_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            loaded_reg <= loaded_next;
            cur_reg    <= cur_next;
            qhead_reg  <= qhead_next;
            qtail_reg  <= qtail_next;
            qfill_reg  <= qfill_next;
            hfill_reg  <= hfill_next;
            done_reg   <= ctrl.exec;
        end
    end

    // Payload registers: command latch, first reads and the result.
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg <= command;
            tid_reg <= TRACK_BITS'(track_id);
        end
        if (ctrl.read_second)
        begin
            first_reg <= q_rdata;
            top_reg   <= h_rdata;
        end
        if (ctrl.exec)
        begin
            event_reg <= event_next;
            rep_reg   <= rep_next;
            drop_reg  <= drop_next;
        end
    end

    assign done           = done_reg;
    assign event_res      = event_reg;
    assign reported_track = to_field(rep_reg);
    assign player_state   = STATE_W'(mode_reg);
    assign loaded_valid   = loaded_reg;
    assign loaded_track   = loaded_reg ? to_field(cur_reg) : '0;
    assign queue_count    = COUNT_W'(qfill_reg);
    assign history_count  = COUNT_W'(hfill_reg);
    assign dropped        = drop_reg;

endmodule

FILE: rtl/tqtc_controller.sv
// Controller: sequences each command through read, latch and execute steps.
`timescale 1ns / 1ps

module tqtc_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output tqtc_pkg::ctrl_t  ctrl
);

    import tqtc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_LATCH = 2'd2,
        ST_EXEC  = 2'd3
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, busy_next;

    // Next state and busy flag.
    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                    busy_next  = 1'b1;
                end
            end
            ST_READ:
            begin
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    // State and registered busy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    // Step commands decoded from the state.
    assign ctrl.capture     = (state_reg == ST_IDLE) && start;
    assign ctrl.read_first  = (state_reg == ST_READ);
    assign ctrl.read_second = (state_reg == ST_LATCH);
    assign ctrl.exec        = (state_reg == ST_EXEC);
    assign busy             = busy_reg;

endmodule

FILE: rtl/tqtc_checker.sv
// Port-level checks of the track queue transport controller, bound to the top level.
`timescale 1ns / 1ps

module tqtc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [3:0]  event_res,
    input logic [15:0] reported_track,
    input logic        loaded_valid,
    input logic [15:0] loaded_track,
    input logic [4:0]  queue_count,
    input logic [4:0]  history_count,
    input logic        dropped
);

    import tqtc_pkg::*;

    // Every accepted command yields its result strobe.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("result strobe missing after an accepted transfer");

    // The block is free again once a result is shown.
    a_idle_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while a result is shown");

    // Fill counts never pass the store depths.
    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (queue_count <= COUNT_W'(QUEUE_DEPTH))
              && (history_count <= COUNT_W'(HISTORY_DEPTH)))
        else $error("fill count beyond store depth");

    // No event means no reported track.
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (event_res == EV_NONE)) |-> (reported_track == '0))
        else $error("track reported without an event");

    // With nothing loaded the loaded track reads zero.
    a_unloaded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !loaded_valid) |-> (loaded_track == '0))
        else $error("loaded track nonzero while nothing is loaded");

endmodule

bind track_queue_transport_controller tqtc_checker u_checker (.*);
